// ===== rtl/hsvrgb_pkg.sv =====
// shared types, constants and helpers for the hsv to rgb pixel core
package hsvrgb_pkg;

   localparam int HueW   = 16;
   localparam int CodeW  = 8;
   localparam int FracW  = 16;
   localparam int SixW   = HueW + 3;
   localparam int NumW   = 24;
   localparam int ProdW  = 32;
   localparam int HiW    = ProdW - FracW;

   // 255 * 65536, one full code times one full turn
   localparam logic [NumW-1:0]  FullScale = 24'd16711680;
   localparam logic [CodeW-1:0] CodeMax   = 8'd255;

   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   // stage three contents handed to the channel select logic
   typedef struct packed {
      sector_type       sector;
      logic             gray;
      logic [CodeW-1:0] val;
      logic [CodeW-1:0] alp;
      logic [HiW-1:0]   pv;
      logic [HiW-1:0]   xq;
      logic [HiW-1:0]   xt;
   } s3_type;

   typedef struct packed {
      logic [CodeW-1:0] red;
      logic [CodeW-1:0] green;
      logic [CodeW-1:0] blue;
      logic [CodeW-1:0] alpha;
   } pixel_type;

   // floor(y / 255) for y up to 65025: estimate by y >> 8, then one correction
   function automatic logic [CodeW-1:0] div255(input logic [HiW-1:0] y);
      logic [CodeW-1:0] est;
      logic [HiW:0]     rem;
      logic [CodeW:0]   quo;
      est = y[HiW-1:CodeW];
      rem = {1'b0, y} - {1'b0, est, 8'b0} + {9'b0, est};
      quo = {1'b0, est} + {8'b0, (rem >= 17'd255)};
      return quo[CodeW-1:0];
   endfunction

endpackage

// ===== rtl/hsvrgb_req_if.sv =====
// request and response channel interfaces of the hsv to rgb pixel core
interface hsvrgb_req_if;
   logic       valid;
   logic       ready;
   logic [15:0] hue;
   logic [7:0]  saturation;
   logic [7:0]  brightness;
   logic [7:0]  alpha_in;

   modport source (output valid, hue, saturation, brightness, alpha_in, input ready);
   modport sink   (input valid, hue, saturation, brightness, alpha_in, output ready);
endinterface

interface hsvrgb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha_out;

   modport source (output valid, red, green, blue, alpha_out, input ready);
   modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

// ===== rtl/hsvrgb_select.sv =====
// final divide by 255 of p, q and t and channel placement by sector
module hsvrgb_select (
   input  hsvrgb_pkg::s3_type    s3,
   output hsvrgb_pkg::pixel_type px
);
   import hsvrgb_pkg::*;

   logic [CodeW-1:0] p_val;
   logic [CodeW-1:0] q_val;
   logic [CodeW-1:0] t_val;

   always_comb begin
      p_val = div255(s3.pv);
      q_val = div255(s3.xq);
      t_val = div255(s3.xt);
      px.alpha = s3.alp;
      case (s3.sector)
         SEC_RED_YEL: begin
            px.red = s3.val; px.green = t_val;  px.blue = p_val;
         end
         SEC_YEL_GRN: begin
            px.red = q_val;  px.green = s3.val; px.blue = p_val;
         end
         SEC_GRN_CYN: begin
            px.red = p_val;  px.green = s3.val; px.blue = t_val;
         end
         SEC_CYN_BLU: begin
            px.red = p_val;  px.green = q_val;  px.blue = s3.val;
         end
         SEC_BLU_MAG: begin
            px.red = t_val;  px.green = p_val;  px.blue = s3.val;
         end
         default: begin
            px.red = s3.val; px.green = p_val;  px.blue = q_val;
         end
      endcase
      // zero saturation gives gray with full opacity
      if (s3.gray) begin
         px.red   = s3.val;
         px.green = s3.val;
         px.blue  = s3.val;
         px.alpha = CodeMax;
      end
   end

endmodule

// ===== rtl/hsv_to_rgb_pixel_core.sv =====
// top level of the hsv to rgb pixel core, a four stage pipeline
//
//   channel  dir  handshake            payload
//   req      in   req.valid/req.ready  hue[16] saturation[8] brightness[8] alpha_in[8]
//   rsp      out  rsp.valid/rsp.ready  red[8] green[8] blue[8] alpha_out[8]
//
// rsp.valid is the registered stage four valid bit; an accepted request moves through the stage registers in order
// one request per cycle sustained while rsp.ready stays high; stage two and three multipliers set the stage depth
// each stage stalls only when it is full and the stage after it cannot take more,
// so bubbles are squeezed out and the input keeps flowing while a result waits,
// until all four stages hold a request
// reset clears the stage valid bits only, the data registers are not reset
module hsv_to_rgb_pixel_core (
   input  logic                clock,
   input  logic                reset,
   hsvrgb_req_if.sink          req,
   hsvrgb_rsp_if.source        rsp
);
   import hsvrgb_pkg::*;

   // stage enables, a stage loads when empty or when its successor loads
   logic en1, en2, en3, en4;

   // stage one: hue times six split into sector and fraction, v*(255-s)
   logic             v1_ff, v1_in;
   sector_type       sec1_ff, sec1_in;
   logic [FracW-1:0] frac1_ff, frac1_in;
   logic [FracW:0]   comp1_ff, comp1_in;
   logic [CodeW-1:0] sat1_ff, val1_ff, alp1_ff;
   logic [HiW-1:0]   pv1_ff, pv1_in;
   logic [SixW-1:0]  six;

   // stage two: numerators of q and t
   logic             v2_ff;
   sector_type       sec2_ff;
   logic             gray2_ff;
   logic [CodeW-1:0] val2_ff, alp2_ff;
   logic [HiW-1:0]   pv2_ff;
   logic [NumW-1:0]  nq2_ff, nq2_in;
   logic [NumW-1:0]  nt2_ff, nt2_in;
   logic [NumW-1:0]  sf_prod;
   logic [NumW:0]    sc_prod;

   // stage three: v times numerator, upper half kept (the divide by 65536)
   logic             v3_ff;
   s3_type           s3_ff, s3_in;
   logic [ProdW-1:0] xq_prod, xt_prod;

   // stage four: output register
   logic             v4_ff;
   logic             gray4_ff;
   pixel_type        px4_ff, px4_in;

   assign en4 = !v4_ff || rsp.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req.ready = en1;
   assign v1_in     = req.valid;

   always_comb begin
      six      = {1'b0, req.hue, 2'b00} + {2'b00, req.hue, 1'b0};
      sec1_in  = sector_type'(six[SixW-1:FracW]);
      frac1_in = six[FracW-1:0];
      comp1_in = 17'h10000 - {1'b0, six[FracW-1:0]};
      pv1_in   = HiW'(req.brightness) * HiW'(CodeMax - req.saturation);
   end

   always_comb begin
      sf_prod = NumW'(sat1_ff) * NumW'(frac1_ff);
      sc_prod = (NumW+1)'(sat1_ff) * (NumW+1)'(comp1_ff);
      nq2_in  = FullScale - sf_prod;
      // s*(65536-f) never exceeds the full scale, so the top bit drops
      nt2_in  = FullScale - sc_prod[NumW-1:0];
   end

   always_comb begin
      xq_prod     = ProdW'(val2_ff) * ProdW'(nq2_ff);
      xt_prod     = ProdW'(val2_ff) * ProdW'(nt2_ff);
      s3_in.sector = sec2_ff;
      s3_in.gray  = gray2_ff;
      s3_in.val   = val2_ff;
      s3_in.alp   = alp2_ff;
      s3_in.pv    = pv2_ff;
      s3_in.xq    = xq_prod[ProdW-1:FracW];
      s3_in.xt    = xt_prod[ProdW-1:FracW];
   end

   hsvrgb_select u_select (
      .s3 (s3_ff),
      .px (px4_in)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= v1_in;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      if (en1) begin
         sec1_ff  <= sec1_in;
         frac1_ff <= frac1_in;
         comp1_ff <= comp1_in;
         sat1_ff  <= req.saturation;
         val1_ff  <= req.brightness;
         alp1_ff  <= req.alpha_in;
         pv1_ff   <= pv1_in;
      end
      if (en2) begin
         sec2_ff  <= sec1_ff;
         gray2_ff <= (sat1_ff == '0);
         val2_ff  <= val1_ff;
         alp2_ff  <= alp1_ff;
         pv2_ff   <= pv1_ff;
         nq2_ff   <= nq2_in;
         nt2_ff   <= nt2_in;
      end
      if (en3) begin
         s3_ff <= s3_in;
      end
      if (en4) begin
         px4_ff   <= px4_in;
         gray4_ff <= s3_ff.gray;
      end
   end

   assign rsp.valid     = v4_ff;
   assign rsp.red       = px4_ff.red;
   assign rsp.green     = px4_ff.green;
   assign rsp.blue      = px4_ff.blue;
   assign rsp.alpha_out = px4_ff.alpha;

   // input is refused only when every stage holds a request
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("request refused with a free pipeline stage");

   // a stalled first stage keeps its request
   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !en2) |=> (v1_ff && $stable(frac1_ff) && $stable(pv1_ff)))
      else $error("stage one request lost during stall");

   // gray results carry equal channels and full opacity
   a_gray_out: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && gray4_ff) |-> (px4_ff.red == px4_ff.green &&
                               px4_ff.green == px4_ff.blue &&
                               px4_ff.alpha == CodeMax))
      else $error("gray pixel with unequal channels or partial alpha");

   // a result that leaves with an empty stage three leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && rsp.ready && !v3_ff) |=> !v4_ff)
      else $error("result repeated after delivery");

endmodule
